@@ design/lsbp_pkg.sv @@
// Shared types and constants for the LED strip bounce/pulse animator.
// No dependencies; imported by the top level, lsbp_step and the bench.
`timescale 1ns / 1ps

package lsbp_pkg;

  // default for the top-level MAX_PIXELS parameter
  localparam int LSBP_MAX_PIXELS = 256;

  // configuration register indexes
  localparam logic CFG_INTERVAL_MS  = 1'b0;
  localparam logic CFG_STRIP_LENGTH = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [8:0]  LENGTH_RESET   = 9'd8;

  // animation levels
  localparam logic [7:0] DIM_RED      = 8'd50;
  localparam logic [7:0] BRIGHT_RED   = 8'd255;
  localparam logic [8:0] PULSE_STEP   = 9'd15;
  localparam logic [8:0] PULSE_TOP    = 9'd240;
  localparam logic [7:0] PULSE_PEAK   = 8'd250;
  localparam logic [7:0] PULSE_BOTTOM = 8'd20;
  localparam logic [7:0] PULSE_FLOOR  = 8'd5;
  localparam logic [7:0] COLOR_DIM    = 8'd10;
  localparam logic [8:0] COLOR_BOOST  = 9'd50;

  typedef struct packed {
    logic [7:0]  spot_pos;
    logic        moving_up;
    logic [7:0]  pulse_level;
    logic [31:0] last_time;
    logic        was_conn;
  } anim_state_t;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic       spot_on;
    logic [7:0] spot_index;
    logic [7:0] spot_red;
    logic [7:0] spot_green;
    logic [7:0] spot_blue;
  } frame_t;

  typedef struct packed {
    logic       action;
    logic       link_up;
    logic [31:0] now_ms;
    logic [7:0] color_red;
    logic [7:0] color_green;
    logic [7:0] color_blue;
  } request_t;

endpackage

@@ design/lsbp_if.sv @@
// Valid/ready channel interfaces for animator requests and frames.
// Depends on nothing; field widths follow the package types.
`timescale 1ns / 1ps

interface lsbp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        link_up;
  logic [31:0] now_ms;
  logic [7:0]  color_red;
  logic [7:0]  color_green;
  logic [7:0]  color_blue;

  modport source (output valid, action, link_up, now_ms, color_red, color_green,
                  color_blue, input ready);
  modport sink (input valid, action, link_up, now_ms, color_red, color_green,
                color_blue, output ready);
endinterface

interface lsbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_red;
  logic [7:0] base_green;
  logic [7:0] base_blue;
  logic       spot_on;
  logic [7:0] spot_index;
  logic [7:0] spot_red;
  logic [7:0] spot_green;
  logic [7:0] spot_blue;

  modport source (output valid, base_red, base_green, base_blue, spot_on, spot_index,
                  spot_red, spot_green, spot_blue, input ready);
  modport sink (input valid, base_red, base_green, base_blue, spot_on, spot_index,
                spot_red, spot_green, spot_blue, output ready);
endinterface

@@ design/led_strip_bounce_pulse_animator.sv @@
// LED strip bounce/pulse animator, top level.
// Depends on lsbp_pkg, lsbp_if (channel interfaces) and lsbp_step.
//
// Usage:
// - in_chan carries requests: action (0 idle tick, 1 color frame), link_up,
//   now_ms and a requested color. A request moves on valid & ready.
// - out_chan carries frames: a base color for all pixels plus an optional
//   highlighted pixel (spot_on, spot_index, spot color).
// - cfg_we/cfg_index/cfg_wdata write interval_ms (index 0) and strip_length
//   (index 1); write only while no frame is pending.
// Timing:
// - A request's frame is registered at the edge that accepts the request.
//   Idle ticks inside the interval give no frame.
// - Throughput is one request per cycle while no frame waits on a stalled
//   receiver. All the step logic sits between the input port and the single
//   output register; that register is the only pipeline stage.
// - in_chan.ready is high whenever the output register is empty or being
//   drained in the same cycle, so a stalled receiver holds off new requests
//   only while a frame is still waiting.
// Reset (synchronous, active low) empties the output, restores the default
// registers and puts the animation back at the start: spot 0, moving up,
// pulse level 0, no frame stamped, link down.
`timescale 1ns / 1ps

module led_strip_bounce_pulse_animator import lsbp_pkg::*; #(
  parameter int MAX_PIXELS = LSBP_MAX_PIXELS
) (
  input  logic              clk,
  input  logic              rst_n,
  lsbp_in_if.sink           in_chan,
  lsbp_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_wdata
);

  anim_state_t st_r, st_nxt;
  request_t    req;
  frame_t      frame_r, frame_nxt;
  logic        out_valid_r;
  logic        emit;
  logic        in_fire;
  logic [15:0] interval_r;
  logic [8:0]  length_r;

  assign req.action      = in_chan.action;
  assign req.link_up     = in_chan.link_up;
  assign req.now_ms      = in_chan.now_ms;
  assign req.color_red   = in_chan.color_red;
  assign req.color_green = in_chan.color_green;
  assign req.color_blue  = in_chan.color_blue;

  // output slot free, or emptied this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  lsbp_step #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_step (
    .st          (st_r),
    .req         (req),
    .interval_ms (interval_r),
    .strip_length(length_r),
    .st_nxt      (st_nxt),
    .emit        (emit),
    .frame       (frame_nxt)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      length_r   <= LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL_MS:  interval_r <= cfg_wdata;
        CFG_STRIP_LENGTH: length_r   <= cfg_wdata[8:0];
        default:          ;
      endcase
    end
  end

  // animation state advances on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.spot_pos    <= 8'd0;
      st_r.moving_up   <= 1'b1;
      st_r.pulse_level <= 8'd0;
      st_r.last_time   <= 32'd0;
      st_r.was_conn    <= 1'b0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      frame_r <= frame_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.base_red   = frame_r.base_red;
  assign out_chan.base_green = frame_r.base_green;
  assign out_chan.base_blue  = frame_r.base_blue;
  assign out_chan.spot_on    = frame_r.spot_on;
  assign out_chan.spot_index = frame_r.spot_index;
  assign out_chan.spot_red   = frame_r.spot_red;
  assign out_chan.spot_green = frame_r.spot_green;
  assign out_chan.spot_blue  = frame_r.spot_blue;

endmodule

@@ design/lsbp_step.sv @@
// Next-state and frame logic for one animator request.
// Depends on lsbp_pkg.
`timescale 1ns / 1ps

module lsbp_step import lsbp_pkg::*; #(
  parameter int MAX_PIXELS = LSBP_MAX_PIXELS
) (
  input  anim_state_t st,
  input  request_t    req,
  input  logic [15:0] interval_ms,
  input  logic [8:0]  strip_length,
  output anim_state_t st_nxt,
  output logic        emit,
  output frame_t      frame
);

  localparam logic [8:0] LEN_TOP = (MAX_PIXELS < 256) ? 9'(MAX_PIXELS) : 9'd256;

  logic [8:0]  len;
  logic [8:0]  pos0;
  logic [8:0]  pos_cl;
  logic [8:0]  pos_inc;
  logic [8:0]  mv_pos;
  logic        mv_up;
  logic [8:0]  pulse_sum;
  logic [7:0]  pulse_nxt;
  logic        pulse_up;
  logic [31:0] elapsed;
  logic        due;
  logic        color_zero;
  logic [8:0]  add_r, add_g, add_b;

  // effective strip length, clamped to 2 .. LEN_TOP
  always_comb begin
    if (strip_length < 9'd2) begin
      len = 9'd2;
    end else if (strip_length > LEN_TOP) begin
      len = LEN_TOP;
    end else begin
      len = strip_length;
    end
  end

  // link change restarts the bounce
  assign pos0 = (req.link_up != st.was_conn) ? 9'd0 : {1'b0, st.spot_pos};

  // bounce step
  always_comb begin
    pos_cl  = (pos0 >= len) ? len - 9'd1 : pos0;
    pos_inc = pos_cl + 9'd1;
    mv_up   = st.moving_up;
    if (st.moving_up) begin
      if (pos_inc >= len) begin
        mv_up  = 1'b0;
        mv_pos = len - 9'd2;
      end else begin
        mv_pos = pos_inc;
      end
    end else if (pos_cl == 9'd0) begin
      mv_up  = 1'b1;
      mv_pos = 9'd1;
    end else begin
      mv_pos = pos_cl - 9'd1;
    end
  end

  // pulse step
  always_comb begin
    pulse_sum = {1'b0, st.pulse_level} + PULSE_STEP;
    pulse_up  = st.moving_up;
    if (st.moving_up) begin
      if (pulse_sum >= PULSE_TOP) begin
        pulse_up  = 1'b0;
        pulse_nxt = PULSE_PEAK;
      end else begin
        pulse_nxt = pulse_sum[7:0];
      end
    end else if (st.pulse_level <= PULSE_BOTTOM) begin
      pulse_up  = 1'b1;
      pulse_nxt = PULSE_FLOOR;
    end else begin
      pulse_nxt = st.pulse_level - PULSE_STEP[7:0];
    end
  end

  assign elapsed    = req.now_ms - st.last_time;
  assign due        = (st.last_time == 32'd0) || (elapsed >= {16'd0, interval_ms});
  assign color_zero = (req.color_red == 8'd0) && (req.color_green == 8'd0) &&
                      (req.color_blue == 8'd0);
  assign add_r      = {1'b0, req.color_red} + COLOR_BOOST;
  assign add_g      = {1'b0, req.color_green} + COLOR_BOOST;
  assign add_b      = {1'b0, req.color_blue} + COLOR_BOOST;

  always_comb begin
    st_nxt          = st;
    st_nxt.was_conn = req.link_up;
    st_nxt.spot_pos = pos0[7:0];
    emit            = 1'b0;
    frame           = '0;
    if (req.action) begin
      emit = 1'b1;
      if (!color_zero) begin
        st_nxt.spot_pos  = mv_pos[7:0];
        st_nxt.moving_up = mv_up;
        frame.base_red   = (req.color_red > COLOR_DIM) ? req.color_red - COLOR_DIM : 8'd0;
        frame.base_green = (req.color_green > COLOR_DIM) ? req.color_green - COLOR_DIM : 8'd0;
        frame.base_blue  = (req.color_blue > COLOR_DIM) ? req.color_blue - COLOR_DIM : 8'd0;
        frame.spot_on    = 1'b1;
        frame.spot_index = mv_pos[7:0];
        frame.spot_red   = add_r[8] ? 8'd255 : add_r[7:0];
        frame.spot_green = add_g[8] ? 8'd255 : add_g[7:0];
        frame.spot_blue  = add_b[8] ? 8'd255 : add_b[7:0];
      end
    end else if (due) begin
      emit             = 1'b1;
      st_nxt.last_time = req.now_ms;
      if (req.link_up) begin
        st_nxt.spot_pos  = mv_pos[7:0];
        st_nxt.moving_up = mv_up;
        frame.base_red   = DIM_RED;
        frame.spot_on    = 1'b1;
        frame.spot_index = mv_pos[7:0];
        frame.spot_red   = BRIGHT_RED;
      end else begin
        st_nxt.pulse_level = pulse_nxt;
        st_nxt.moving_up   = pulse_up;
        frame.base_red     = pulse_nxt;
      end
    end
  end

endmodule

@@ design/lsbp_checker.sv @@
// Port-level checks for the animator, bound to the top level.
// Depends on led_strip_bounce_pulse_animator and its channel interfaces.
`timescale 1ns / 1ps

module lsbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] base_red,
  input logic       spot_on,
  input logic [7:0] spot_index,
  input logic [7:0] spot_red,
  input logic [7:0] spot_green,
  input logic [7:0] spot_blue
);

  // a pending frame stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("frame dropped while stalled");

  // color requests always produce a frame
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> out_valid)
    else $error("color request gave no frame");

  // highlight fields are clear when there is no highlight
  a_nospot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !spot_on |-> spot_index == 8'd0 && spot_red == 8'd0 &&
      spot_green == 8'd0 && spot_blue == 8'd0)
    else $error("highlight fields set without spot");

  // highlight is never dimmer than the base
  a_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && spot_on |-> spot_red >= base_red)
    else $error("highlight dimmer than base");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("frame valid after reset");

endmodule

bind led_strip_bounce_pulse_animator lsbp_checker u_lsbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_action (in_chan.action),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .base_red  (out_chan.base_red),
  .spot_on   (out_chan.spot_on),
  .spot_index(out_chan.spot_index),
  .spot_red  (out_chan.spot_red),
  .spot_green(out_chan.spot_green),
  .spot_blue (out_chan.spot_blue)
);

@@ tb/sv/led_strip_bounce_pulse_animator_tb.sv @@
// Self-checking bench for the LED strip bounce/pulse animator: directed and
// random requests over the valid/ready channels, frames checked in order.
// Depends on lsbp_pkg (types, register indexes, levels) and lsbp_if.
`timescale 1ns / 1ps

module led_strip_bounce_pulse_animator_tb;
  import lsbp_pkg::*;

  // request kinds carried in the action bit
  localparam logic ACT_IDLE  = 1'b0;
  localparam logic ACT_COLOR = 1'b1;

  // cycles with no handshake on either side before the run is called hung;
  // far above the longest source gap plus sink stall plus register pause
  localparam int QUIET_LIMIT  = 5000;
  // pause after draining; the output register is the only stage
  localparam int DRAIN_CYCLES = 4;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  lsbp_in_if  req_ch ();
  lsbp_out_if frm_ch ();

  led_strip_bounce_pulse_animator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_ch),
    .out_chan  (frm_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset asserted from time zero, released on a falling edge, never raised again
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Animation model: own copy of the registers and of the animation state.
  // Updated once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [15:0] interval_cfg = INTERVAL_RESET;
  logic [8:0]  length_cfg   = LENGTH_RESET;

  int unsigned spot_pos   = 0;
  bit          heading_up = 1'b1;  // shared by bounce and pulse
  int unsigned pulse_lvl  = 0;
  logic [31:0] last_stamp = '0;    // 0 reads as "no frame yet"
  bit          link_seen  = 1'b0;

  // strip length in use: register clamped to 2 .. min(MAX_PIXELS, 256)
  function automatic int unsigned strip_span();
    int unsigned top;
    int unsigned n;
    top = (LSBP_MAX_PIXELS < 256) ? LSBP_MAX_PIXELS : 256;
    n = 32'(length_cfg);
    if (n < 2) n = 2;
    if (n > top) n = top;
    return n;
  endfunction

  // one bounce step; a spot left past the end by a shrink is pulled in first
  function automatic void advance_spot();
    int unsigned n;
    n = strip_span();
    if (spot_pos >= n) spot_pos = n - 1;
    if (heading_up) begin
      spot_pos++;
      if (spot_pos >= n) begin
        heading_up = 1'b0;
        spot_pos = n - 2;
      end
    end else if (spot_pos == 0) begin
      heading_up = 1'b1;
      spot_pos = 1;
    end else begin
      spot_pos--;
    end
  endfunction

  function automatic logic [7:0] dim_level(logic [7:0] v);
    return (v > COLOR_DIM) ? v - COLOR_DIM : 8'd0;
  endfunction

  function automatic logic [7:0] boost_level(logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, v} + COLOR_BOOST;
    return (s > 9'd255) ? 8'd255 : s[7:0];
  endfunction

  // returns 1 and the frame when the request produces one
  function automatic bit predict_frame(input request_t rq, output frame_t fr);
    logic [31:0] elapsed;
    fr = '0;
    // link change restarts the bounce at pixel 0
    if (rq.link_up != link_seen) begin
      spot_pos = 0;
      link_seen = rq.link_up;
    end
    if (rq.action == ACT_COLOR) begin
      // all-zero color means blank strip, spot does not move
      if (rq.color_red == 8'd0 && rq.color_green == 8'd0 && rq.color_blue == 8'd0)
        return 1'b1;
      advance_spot();
      fr.base_red   = dim_level(rq.color_red);
      fr.base_green = dim_level(rq.color_green);
      fr.base_blue  = dim_level(rq.color_blue);
      fr.spot_on    = 1'b1;
      fr.spot_index = spot_pos[7:0];
      fr.spot_red   = boost_level(rq.color_red);
      fr.spot_green = boost_level(rq.color_green);
      fr.spot_blue  = boost_level(rq.color_blue);
      return 1'b1;
    end
    // idle tick: elapsed time wraps modulo 2^32
    elapsed = rq.now_ms - last_stamp;
    if (last_stamp != 32'd0 && elapsed < {16'd0, interval_cfg})
      return 1'b0;
    if (link_seen) begin
      advance_spot();
      fr.base_red   = DIM_RED;
      fr.spot_on    = 1'b1;
      fr.spot_index = spot_pos[7:0];
      fr.spot_red   = BRIGHT_RED;
    end else begin
      if (heading_up) begin
        pulse_lvl += 32'(PULSE_STEP);
        if (pulse_lvl >= 32'(PULSE_TOP)) begin
          heading_up = 1'b0;
          pulse_lvl = 32'(PULSE_PEAK);
        end
      end else if (pulse_lvl <= 32'(PULSE_BOTTOM)) begin
        heading_up = 1'b1;
        pulse_lvl = 32'(PULSE_FLOOR);
      end else begin
        pulse_lvl -= 32'(PULSE_STEP);
      end
      fr.base_red = pulse_lvl[7:0];
    end
    last_stamp = rq.now_ms;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  request_t    pending_reqs[$];
  frame_t      expected_frames[$];

  bit          req_taken;      // set at the rising edge a request moves
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned calm_timer;
  bit          send_calm;      // stretches with no source gaps
  bit          sink_calm;      // stretches with no sink stalls
  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned color_reqs;
  int unsigned frames_checked;
  int unsigned silent_ticks;
  int unsigned cfg_writes;
  int unsigned quiet;
  int unsigned errors;
  logic [31:0] clock_ms;       // running millisecond clock for idle ticks

  // mostly short gaps, some medium, a rare long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("frame field %s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. Output is checked
  // before the new request is modeled; a frame only leaves the output register
  // after its request, so the order does not matter; it keeps the queue short.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    request_t rq;
    frame_t   got;
    frame_t   want;
    int       bad;
    req_taken = 1'b0;
    if (rst_n) begin
      if (frm_ch.valid && frm_ch.ready) begin
        got = {frm_ch.base_red, frm_ch.base_green, frm_ch.base_blue, frm_ch.spot_on,
               frm_ch.spot_index, frm_ch.spot_red, frm_ch.spot_green, frm_ch.spot_blue};
        if (expected_frames.size() == 0) begin
          $error("frame arrived with none expected (base_red %0d, spot_on %0d)",
                 got.base_red, got.spot_on);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          bad = field_diff("base_red",   want.base_red,   got.base_red)
              + field_diff("base_green", want.base_green, got.base_green)
              + field_diff("base_blue",  want.base_blue,  got.base_blue)
              + field_diff("spot_on",    {7'd0, want.spot_on}, {7'd0, got.spot_on})
              + field_diff("spot_index", want.spot_index, got.spot_index)
              + field_diff("spot_red",   want.spot_red,   got.spot_red)
              + field_diff("spot_green", want.spot_green, got.spot_green)
              + field_diff("spot_blue",  want.spot_blue,  got.spot_blue);
          if (bad != 0) errors++;
          frames_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        rq = {req_ch.action, req_ch.link_up, req_ch.now_ms,
              req_ch.color_red, req_ch.color_green, req_ch.color_blue};
        req_taken = 1'b1;
        accepted_total++;
        if (rq.action == ACT_COLOR) color_reqs++;
        if (predict_frame(rq, want)) expected_frames.push_back(want);
        else silent_ticks++;
      end
      // watchdog on handshake activity
      if (req_taken || (frm_ch.valid && frm_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d frames still expected",
                 quiet, expected_frames.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: everything changes on the falling edge. Next values are worked out
  // in locals so each port gets at most one nonblocking write per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_channels
    request_t nq;
    logic     nv;
    logic     nr;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      frm_ch.ready <= 1'b0;
    end else begin
      if (calm_timer == 0) begin
        calm_timer = $urandom_range(200, 20);
        send_calm = ($urandom_range(3) == 0);
        sink_calm = ($urandom_range(3) == 0);
      end else begin
        calm_timer--;
      end

      // source side: hold the request until it moves, then gap, then next
      nv = req_ch.valid;
      nq = {req_ch.action, req_ch.link_up, req_ch.now_ms,
            req_ch.color_red, req_ch.color_green, req_ch.color_blue};
      if (nv && req_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          nq = pending_reqs.pop_front();
          nv = 1'b1;
          send_gap = pick_gap(send_calm);
        end
      end

      // sink side: random stalls of random length
      if (stall_left != 0) begin
        stall_left--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (!sink_calm && $urandom_range(99) < 30) stall_left = pick_gap(1'b0);
      end

      req_ch.valid       <= nv;
      req_ch.action      <= nq.action;
      req_ch.link_up     <= nq.link_up;
      req_ch.now_ms      <= nq.now_ms;
      req_ch.color_red   <= nq.color_red;
      req_ch.color_green <= nq.color_green;
      req_ch.color_blue  <= nq.color_blue;
      frm_ch.ready       <= nr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(logic act, logic link, logic [31:0] now,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pending_reqs.push_back({act, link, now, r, g, b});
    queued_total++;
  endtask

  // every request moved, every frame seen, then a short pause for the
  // output stage before anything touches the registers
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_total != queued_total || expected_frames.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // model copy follows the port write; the block is idle here
  task automatic write_reg(logic idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_INTERVAL_MS) interval_cfg = data;
    else length_cfg = data[8:0];
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // length register: junk in the unused upper bits, which must be ignored
  task automatic write_length(logic [8:0] len);
    write_reg(CFG_STRIP_LENGTH, {7'($urandom), len});
  endtask

  // idle-tick timestamps: mostly around the interval edge, plus jumps,
  // wraps and time zero
  function automatic logic [31:0] next_time();
    int unsigned r;
    int          step;
    r = $urandom_range(99);
    if (r < 50) begin
      step = int'(interval_cfg) + int'($urandom_range(4)) - 2;
      if (step < 0) step = 0;
      clock_ms += step;
    end else if (r < 70) begin
      clock_ms += $urandom_range(interval_cfg);
    end else if (r < 80) begin
      clock_ms += $urandom();
    end else if (r < 88) begin
      clock_ms = $urandom();
    end else if (r < 93) begin
      clock_ms = '0;
    end else begin
      clock_ms += 1;
    end
    return clock_ms;
  endfunction

  // color levels weighted toward the saturation edges
  function automatic logic [7:0] pick_level();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 25) return 8'd10 + 8'($urandom_range(1));
    if (r < 35) return 8'd205 + 8'($urandom_range(1));
    if (r < 45) return 8'd255;
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_random(int count, logic link_start, int unsigned flip_pct);
    logic       link;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    link = link_start;
    // fill on a rising edge so the driver never pops in the same step
    @(posedge clk);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < flip_pct) link = ~link;
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(9) == 0) begin
          r = 8'd0;
          g = 8'd0;
          b = 8'd0;
        end else begin
          r = pick_level();
          g = pick_level();
          b = pick_level();
        end
        queue_req(ACT_COLOR, link, $urandom(), r, g, b);
      end else begin
        queue_req(ACT_IDLE, link, next_time(), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_IDLE;
    req_ch.link_up     = 1'b0;
    req_ch.now_ms      = '0;
    req_ch.color_red   = '0;
    req_ch.color_green = '0;
    req_ch.color_blue  = '0;
    frm_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_INTERVAL_MS;
    cfg_wdata          = '0;
    clock_ms           = '0;
    wait (rst_n === 1'b1);

    // Directed, default registers (interval 100, 8 pixels)
    @(posedge clk);
    queue_req(ACT_IDLE,  1'b0, 32'd0,   8'd0, 8'd0, 8'd0);  // no frame yet -> emits
    queue_req(ACT_IDLE,  1'b0, 32'd50,  8'd0, 8'd0, 8'd0);  // stamp 0 reads as none
    queue_req(ACT_IDLE,  1'b0, 32'd149, 8'd0, 8'd0, 8'd0);  // 99 ms: too soon
    queue_req(ACT_IDLE,  1'b0, 32'd150, 8'd0, 8'd0, 8'd0);  // exactly the interval
    queue_req(ACT_IDLE,  1'b1, 32'd150, 8'd0, 8'd0, 8'd0);  // link up, too soon
    queue_req(ACT_IDLE,  1'b1, 32'd250, 8'd0, 8'd0, 8'd0);  // connected bounce
    queue_req(ACT_COLOR, 1'b1, 32'hFFFF_FFFF, 8'd0, 8'd0, 8'd0);      // black
    queue_req(ACT_COLOR, 1'b1, 32'd0, 8'd255, 8'd255, 8'd255);         // full white
    queue_req(ACT_COLOR, 1'b1, 32'd0, 8'd10, 8'd0, 8'd5);              // dim floors
    queue_req(ACT_COLOR, 1'b1, 32'd0, 8'd11, 8'd205, 8'd206);          // boost edge
    queue_req(ACT_COLOR, 1'b0, 32'd0, 8'd1, 8'd0, 8'd0);               // link drop
    queue_req(ACT_IDLE,  1'b0, 32'hFFFF_FFF0, 8'hFF, 8'hFF, 8'hFF);    // near wrap
    queue_req(ACT_IDLE,  1'b0, 32'h0000_0050, 8'd0, 8'd0, 8'd0);       // 96 across wrap
    queue_req(ACT_IDLE,  1'b0, 32'h0000_0054, 8'd0, 8'd0, 8'd0);       // 100 across wrap
    queue_req(ACT_IDLE,  1'b0, 32'h0000_00B7, 8'd0, 8'd0, 8'd0);       // 99 again
    queue_req(ACT_COLOR, 1'b0, 32'hAAAA_5555, 8'd0, 8'd0, 8'd1);
    wait_drained();

    // zero interval, shortest strip: every tick emits, tight bounce
    write_reg(CFG_INTERVAL_MS, 16'd0);
    write_length(9'd2);
    queue_random(80, 1'b0, 10);

    // length below the minimum gets clamped up
    write_reg(CFG_INTERVAL_MS, 16'd1);
    write_length(9'd0);
    queue_random(60, 1'b1, 10);

    write_reg(CFG_INTERVAL_MS, 16'd3);
    write_length(9'd1);
    queue_random(40, 1'b0, 5);

    // longest strip (511 clamps to 256): a long connected walk so the spot
    // reaches the far end
    write_reg(CFG_INTERVAL_MS, 16'd0);
    write_length(9'd511);
    queue_random(270, 1'b1, 0);

    // strip shrinks under a far-out spot; widest interval
    write_reg(CFG_INTERVAL_MS, 16'hFFFF);
    write_length(9'd5);
    queue_random(80, 1'b1, 3);

    write_reg(CFG_INTERVAL_MS, 16'($urandom_range(5000, 2)));
    write_length(9'd300);
    queue_random(80, 1'b0, 10);

    // back to the reset values
    write_reg(CFG_INTERVAL_MS, INTERVAL_RESET);
    write_length(LENGTH_RESET);
    queue_random(100, 1'b0, 8);

    write_reg(CFG_INTERVAL_MS, 16'($urandom));
    write_length(9'($urandom));
    queue_random(60, 1'b1, 10);

    $display("covered %0d requests (%0d color frames) across %0d register writes",
             accepted_total, color_reqs, cfg_writes);
    $display("%0d frames compared, %0d idle ticks held back by the interval",
             frames_checked, silent_ticks);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
